// ===== rtl/ngh_pkg.sv =====
// Shared types and constants for the noise gate with hold and hysteresis.
// Used by ngh_cfg, ngh_mac and noise_gate_hold_hysteresis; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ngh_pkg;

    // Channel count the build supports; only two sample ports exist.
    localparam int CHANNELS = 2;

    localparam int SAMPLE_W = 24;
    localparam int LEVEL_W  = 23;
    localparam int COEF_W   = 24;
    localparam int HOLD_W   = 17;
    localparam int ACH_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Shared multiply-accumulate operand and accumulator widths
    localparam int MAC_A_W   = 26;
    localparam int MAC_B_W   = 25;
    localparam int MAC_ACC_W = 51;

    localparam logic [COEF_W:0]     ONE_Q24   = 25'd16777216;
    localparam logic [SAMPLE_W-1:0] UNITY_Q23 = 24'd8388608;
    localparam logic [SAMPLE_W-1:0] FLOOR_Q23 = 24'd251658;

    // Register reset values
    localparam logic [LEVEL_W-1:0] RST_OPEN_TH   = 23'd83886;
    localparam logic [LEVEL_W-1:0] RST_CLOSE_TH  = 23'd52930;
    localparam logic [COEF_W-1:0]  RST_DET_ATK   = 24'd16545860;
    localparam logic [COEF_W-1:0]  RST_DET_REL   = 24'd16771840;
    localparam logic [COEF_W-1:0]  RST_GAIN_ATK  = 24'd16707460;
    localparam logic [COEF_W-1:0]  RST_GAIN_REL  = 24'd16773720;
    localparam logic [HOLD_W-1:0]  RST_HOLD      = 17'd2400;
    localparam logic [ACH_W-1:0]   RST_ACTIVE_CH = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OPEN_TH   = 3'd0,
        REG_CLOSE_TH  = 3'd1,
        REG_DET_ATK   = 3'd2,
        REG_DET_REL   = 3'd3,
        REG_GAIN_ATK  = 3'd4,
        REG_GAIN_REL  = 3'd5,
        REG_HOLD      = 3'd6,
        REG_ACTIVE_CH = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [LEVEL_W-1:0] open_threshold;
        logic [LEVEL_W-1:0] close_threshold;
        logic [COEF_W-1:0]  detector_attack_coef;
        logic [COEF_W-1:0]  detector_release_coef;
        logic [COEF_W-1:0]  gain_attack_coef;
        logic [COEF_W-1:0]  gain_release_coef;
        logic [HOLD_W-1:0]  hold_samples;
        logic [ACH_W-1:0]   active_channels;
    } t_cfg;

    // MAC control: en loads the accumulator, accum adds to the old value
    typedef struct packed {
        logic en;
        logic accum;
    } t_mac_op;

endpackage

`default_nettype wire

// ===== rtl/noise_gate_hold_hysteresis.sv =====
// Top level of the noise gate with hold and hysteresis: sequencer, state
// and output register around one shared MAC. Depends on ngh_pkg, ngh_cfg, ngh_mac.
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Direction | Handshake                | Payload
// ----------+-----------+--------------------------+-------------------------------------
// in        | input     | i_in_valid / o_in_stall  | i_sample_ch0/1, i_frame_last
// out       | output    | o_out_valid / i_out_stall| o_out_ch0/1, o_gate_is_open,
//           |           |                          | o_gate_gain, o_block_end
// cfg       | input     | i_cfg_we                 | i_cfg_index, i_cfg_data
//
// The result register loads as the sequencer leaves its last step, S_O2; a new
// item is accepted only in S_IDLE, so it waits until the 9 sequencer steps of
// the last one are through. All six products of the two one-pole updates and
// of the two gain products go through the single MAC, one product per step.
// Reset (synchronous, i_rst_n low) clears detector, gate, hold, envelope and
// loads the register defaults. A stalled output holds the sequencer in its
// last step; the next item may be accepted while a result waits.

module noise_gate_hold_hysteresis
    import ngh_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // input items
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic signed [SAMPLE_W-1:0]  i_sample_ch0,
    input  wire logic signed [SAMPLE_W-1:0]  i_sample_ch1,
    input  wire logic                        i_frame_last,
    // result items
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic signed [SAMPLE_W-1:0]       o_out_ch0,
    output logic signed [SAMPLE_W-1:0]       o_out_ch1,
    output logic                             o_gate_is_open,
    output logic [SAMPLE_W-1:0]              o_gate_gain,
    output logic                             o_block_end,
    // configuration
    input  wire logic                        i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]       i_cfg_data
);

    // Usable channel limit, at least 1 and at most the two sample ports
    localparam int LIMIT = (CHANNELS < 2) ? CHANNELS : 2;
    localparam int QW    = MAC_ACC_W - 23;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_D1   = 10'b00_0000_0010,  // coef * detector
        S_D2   = 10'b00_0000_0100,  // + (1 - coef) * peak
        S_D3   = 10'b00_0000_1000,  // new detector, gate/hold decision
        S_G1   = 10'b00_0001_0000,  // coef * envelope
        S_G2   = 10'b00_0010_0000,  // + (1 - coef) * target
        S_G3   = 10'b00_0100_0000,  // new envelope
        S_O0   = 10'b00_1000_0000,  // ch0 * envelope
        S_O1   = 10'b01_0000_0000,  // store ch0, ch1 * envelope
        S_O2   = 10'b10_0000_0000   // store ch1, hand off result
    } t_state;

    // Saturated Q0.23 magnitude of a Q1.23 sample
    function automatic logic [LEVEL_W-1:0] sat_mag(input logic signed [SAMPLE_W-1:0] s);
        logic [SAMPLE_W-1:0] neg;
        neg = ~s + 1'b1;
        if (!s[SAMPLE_W-1]) begin
            sat_mag = s[LEVEL_W-1:0];
        end else if (neg[SAMPLE_W-1]) begin
            sat_mag = {LEVEL_W{1'b1}};  // full-scale negative
        end else begin
            sat_mag = neg[LEVEL_W-1:0];
        end
    endfunction

    // floor(p / 2^23) saturated to Q1.23
    function automatic logic [SAMPLE_W-1:0] sat_out(input logic signed [MAC_ACC_W-1:0] p);
        logic signed [QW-1:0] q;
        q = p[MAC_ACC_W-1:23];
        if (q > QW'(signed'(24'sh7FFFFF))) begin
            sat_out = 24'h7FFFFF;
        end else if (q < QW'(signed'(24'sh800000))) begin
            sat_out = 24'h800000;
        end else begin
            sat_out = q[SAMPLE_W-1:0];
        end
    endfunction

    t_cfg w_cfg;

    ngh_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    t_state r_state, n_state;

    // Item registers
    logic signed [SAMPLE_W-1:0] r_s0, r_s1;
    logic                       r_last;
    logic [LEVEL_W-1:0]         r_peak;

    // Gate state
    logic [LEVEL_W-1:0]  r_det, n_det;
    logic                r_open, n_open;
    logic [HOLD_W-1:0]   r_hold, n_hold;
    logic [SAMPLE_W-1:0] r_env, n_env;

    // Result register
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out0, r_out1, r_o0_tmp;
    logic                r_out_open;
    logic [SAMPLE_W-1:0] r_out_gain;
    logic                r_out_last;

    // MAC interface
    t_mac_op                     w_op;
    logic signed [MAC_A_W-1:0]   w_a;
    logic signed [MAC_B_W-1:0]   w_b;
    logic signed [MAC_ACC_W-1:0] w_acc;

    ngh_mac u_mac (
        .i_clk (i_clk),
        .i_op  (w_op),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_acc (w_acc)
    );

    logic                w_two_ch;
    logic                w_in_acc;
    logic                w_out_free;
    logic [LEVEL_W-1:0]  w_mag0, w_mag1, w_peak;
    logic [COEF_W-1:0]   w_det_coef, w_gain_coef;
    logic [SAMPLE_W-1:0] w_target;
    logic [LEVEL_W-1:0]  w_new_det;

    // active_channels of 0 acts as 1; above the limit acts as the limit
    assign w_two_ch   = (LIMIT >= 2) && (w_cfg.active_channels >= 2'd2);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Linked peak over the active channels, taken at acceptance
    assign w_mag0 = sat_mag(i_sample_ch0);
    assign w_mag1 = sat_mag(i_sample_ch1);
    assign w_peak = (w_two_ch && (w_mag1 > w_mag0)) ? w_mag1 : w_mag0;

    // Attack when rising, release otherwise; state is stable across D1/D2, G1/G2
    assign w_det_coef  = (r_peak > r_det) ? w_cfg.detector_attack_coef
                                          : w_cfg.detector_release_coef;
    assign w_target    = r_open ? UNITY_Q23 : FLOOR_Q23;
    assign w_gain_coef = (w_target > r_env) ? w_cfg.gain_attack_coef
                                            : w_cfg.gain_release_coef;
    // Sum stays below 2^48, so bits above 47 are zero; detector keeps 23 bits
    assign w_new_det   = w_acc[46:24];

    always_comb begin
        n_state  = r_state;
        n_det    = r_det;
        n_open   = r_open;
        n_hold   = r_hold;
        n_env    = r_env;
        w_op     = '{en: 1'b0, accum: 1'b0};
        w_a      = '0;
        w_b      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_D1;
                end
            end
            S_D1: begin
                w_op    = '{en: 1'b1, accum: 1'b0};
                w_a     = MAC_A_W'(w_det_coef);
                w_b     = MAC_B_W'(r_det);
                n_state = S_D2;
            end
            S_D2: begin
                w_op    = '{en: 1'b1, accum: 1'b1};
                w_a     = MAC_A_W'(ONE_Q24 - {1'b0, w_det_coef});
                w_b     = MAC_B_W'(r_peak);
                n_state = S_D3;
            end
            S_D3: begin
                n_det = w_new_det;
                // Open and reload hold at threshold; else run hold down,
                // then close only below the lower threshold
                if (w_new_det >= w_cfg.open_threshold) begin
                    n_open = 1'b1;
                    n_hold = w_cfg.hold_samples;
                end else if (r_open && (r_hold != '0)) begin
                    n_hold = r_hold - 1'b1;
                end else if (w_new_det < w_cfg.close_threshold) begin
                    n_open = 1'b0;
                end
                n_state = S_G1;
            end
            S_G1: begin
                w_op    = '{en: 1'b1, accum: 1'b0};
                w_a     = MAC_A_W'(w_gain_coef);
                w_b     = MAC_B_W'(r_env);
                n_state = S_G2;
            end
            S_G2: begin
                w_op    = '{en: 1'b1, accum: 1'b1};
                w_a     = MAC_A_W'(ONE_Q24 - {1'b0, w_gain_coef});
                w_b     = MAC_B_W'(w_target);
                n_state = S_G3;
            end
            S_G3: begin
                n_env   = w_acc[47:24];
                n_state = S_O0;
            end
            S_O0: begin
                w_op    = '{en: 1'b1, accum: 1'b0};
                w_a     = MAC_A_W'(r_s0);
                w_b     = MAC_B_W'(r_env);
                n_state = S_O1;
            end
            S_O1: begin
                w_op    = '{en: 1'b1, accum: 1'b0};
                w_a     = MAC_A_W'(r_s1);
                w_b     = MAC_B_W'(r_env);
                n_state = S_O2;
            end
            S_O2: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_det       <= '0;
            r_open      <= 1'b0;
            r_hold      <= '0;
            r_env       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_det   <= n_det;
            r_open  <= n_open;
            r_hold  <= n_hold;
            r_env   <= n_env;
            if ((r_state == S_O2) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s0   <= i_sample_ch0;
            r_s1   <= i_sample_ch1;
            r_last <= i_frame_last;
            r_peak <= w_peak;
        end
        if (r_state == S_O1) begin
            r_o0_tmp <= sat_out(w_acc);
        end
        if ((r_state == S_O2) && w_out_free) begin
            r_out0     <= r_o0_tmp;
            // inactive channel passes through untouched
            r_out1     <= w_two_ch ? sat_out(w_acc) : r_s1;
            r_out_open <= r_open;
            r_out_gain <= r_env;
            r_out_last <= r_last;
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_out_ch0      = r_out0;
    assign o_out_ch1      = r_out1;
    assign o_gate_is_open = r_out_open;
    assign o_gate_gain    = r_out_gain;
    assign o_block_end    = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/ngh_cfg.sv =====
// Configuration register file for the noise gate.
// Depends on ngh_pkg (t_cfg, register indexes, reset values).
`timescale 1ns / 1ps
`default_nettype none

module ngh_cfg
    import ngh_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_OPEN_TH:   n_cfg.open_threshold        = i_cfg_data[LEVEL_W-1:0];
                REG_CLOSE_TH:  n_cfg.close_threshold       = i_cfg_data[LEVEL_W-1:0];
                REG_DET_ATK:   n_cfg.detector_attack_coef  = i_cfg_data[COEF_W-1:0];
                REG_DET_REL:   n_cfg.detector_release_coef = i_cfg_data[COEF_W-1:0];
                REG_GAIN_ATK:  n_cfg.gain_attack_coef      = i_cfg_data[COEF_W-1:0];
                REG_GAIN_REL:  n_cfg.gain_release_coef     = i_cfg_data[COEF_W-1:0];
                REG_HOLD:      n_cfg.hold_samples          = i_cfg_data[HOLD_W-1:0];
                REG_ACTIVE_CH: n_cfg.active_channels       = i_cfg_data[ACH_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.open_threshold        <= RST_OPEN_TH;
            r_cfg.close_threshold       <= RST_CLOSE_TH;
            r_cfg.detector_attack_coef  <= RST_DET_ATK;
            r_cfg.detector_release_coef <= RST_DET_REL;
            r_cfg.gain_attack_coef      <= RST_GAIN_ATK;
            r_cfg.gain_release_coef     <= RST_GAIN_REL;
            r_cfg.hold_samples          <= RST_HOLD;
            r_cfg.active_channels       <= RST_ACTIVE_CH;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/ngh_mac.sv =====
// Shared signed multiply-accumulate unit: acc = (accum ? acc : 0) + a * b.
// Depends on ngh_pkg (operand widths, t_mac_op).
`timescale 1ns / 1ps
`default_nettype none

module ngh_mac
    import ngh_pkg::*;
(
    input  wire logic                        i_clk,
    input  t_mac_op                          i_op,
    input  wire logic signed [MAC_A_W-1:0]   i_a,
    input  wire logic signed [MAC_B_W-1:0]   i_b,
    output logic signed [MAC_ACC_W-1:0]      o_acc
);

    logic signed [MAC_ACC_W-1:0] r_acc;
    logic signed [MAC_ACC_W-1:0] n_acc;

    always_comb begin
        n_acc = MAC_ACC_W'(i_a * i_b);
        if (i_op.accum) begin
            n_acc = n_acc + r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire
